// ===== src/utt_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder package
// Shared payload types, decode action codes and UTF-16 constants.
// ----------------------------------------------------------------------------
`default_nettype none

package utt_pkg;

  // Input transfer payload: one UTF-8 byte and the end-of-string mark.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } byte_item_t;

  // Output transfer payload: one UTF-16 code unit with its flags.
  typedef struct packed {
    logic [15:0] utf16_unit;
    logic        last_of_run;
    logic        string_done;
    logic        was_substitute;
  } unit_item_t;

  // What the decoder decides for the byte at the head of the window.
  typedef enum logic [1:0] {
    ACT_STOP  = 2'd0,
    ACT_UNIT  = 2'd1,
    ACT_PAIR  = 2'd2,
    ACT_SUBST = 2'd3
  } act_kind_t;

  typedef struct packed {
    act_kind_t   kind;
    logic [15:0] unit_hi;
    logic [15:0] unit_lo;
    logic [2:0]  consume;
  } act_t;

  localparam logic [15:0] SUBST_UNIT   = 16'h0023;
  localparam logic [20:0] SUPP_BASE    = 21'h10000;
  localparam logic [15:0] HI_SURR_BASE = 16'hD800;
  localparam logic [15:0] LO_SURR_BASE = 16'hDC00;
  localparam logic [9:0]  SURR_MASK    = 10'h3FF;

  localparam int unsigned WIN_DEPTH = 4;

endpackage : utt_pkg

`default_nettype wire

// ===== src/utt_decode.sv =====
// ----------------------------------------------------------------------------
// UTF-8 sequence decoder
// Looks at the head of the byte window and decides one step: emit a unit,
// emit a surrogate pair, emit a substitute, or stop and wait for more bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module utt_decode
  import utt_pkg::*;
(
  input  wire logic [7:0] win [WIN_DEPTH],
  input  wire logic [2:0] fill,
  input  wire logic       end_seen,
  output act_t            act
);

  // Sequence length taken from the lead byte; 0 is a continuation, 5 invalid.
  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] seq_len;
    if (b[7] == 1'b0)            seq_len = 3'd1;
    else if (b[6] == 1'b0)       seq_len = 3'd0;
    else if (b[5] == 1'b0)       seq_len = 3'd2;
    else if (b[4] == 1'b0)       seq_len = 3'd3;
    else if (b[3] == 1'b0)       seq_len = 3'd4;
    else                         seq_len = 3'd5;
    return seq_len;
  endfunction

  logic [2:0]  len;
  logic [2:0]  chk;
  logic        bad;
  logic [20:0] cp;
  logic [20:0] adj;

  always_comb begin
    len = lead_len(win[0]);
    chk = (fill < len) ? fill : len;
    bad = 1'b0;
    for (int j = 1; j < WIN_DEPTH; j++) begin
      if ((3'(j) < chk) && (win[j][7:6] != 2'b10)) bad = 1'b1;
    end

    unique case (len)
      3'd2:    cp = {10'd0, win[0][4:0], win[1][5:0]};
      3'd3:    cp = {5'd0, win[0][3:0], win[1][5:0], win[2][5:0]};
      default: cp = {win[0][2:0], win[1][5:0], win[2][5:0], win[3][5:0]};
    endcase
    adj = cp - SUPP_BASE;

    act.kind    = ACT_STOP;
    act.unit_hi = SUBST_UNIT;
    act.unit_lo = LO_SURR_BASE + {6'd0, adj[9:0] & SURR_MASK};
    act.consume = 3'd1;

    if (fill == 3'd0) begin
      act.kind = ACT_STOP;
    end else if (len == 3'd1) begin
      act.kind    = ACT_UNIT;
      act.unit_hi = {8'd0, win[0]};
    end else if ((len == 3'd0) || (len == 3'd5)) begin
      act.kind = ACT_SUBST;
    end else if (bad || ((fill < len) && end_seen)) begin
      act.kind = ACT_SUBST;
    end else if (fill < len) begin
      act.kind = ACT_STOP;
    end else begin
      act.consume = len;
      if (cp[20:16] != 5'd0) begin
        act.kind    = ACT_PAIR;
        act.unit_hi = HI_SURR_BASE + {5'd0, adj[20:10]};
      end else begin
        act.kind    = ACT_UNIT;
        act.unit_hi = cp[15:0];
      end
    end
  end

endmodule : utt_decode

`default_nettype wire

// ===== src/utf8_to_utf16_transcoder.sv =====
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder
// Streams UTF-8 bytes in and UTF-16 code units out, with '#' substitutes.
// ----------------------------------------------------------------------------
// The block takes one UTF-8 byte per input transfer and works on it alone:
// byte_ready is high only while the sequencer is idle. The byte is appended
// to a four-byte window that also holds up to three bytes of an unfinished
// sequence. A single decoder then looks at the head of the window once per
// cycle while the output is not stalled, and each look either produces one
// code unit (the high half of a surrogate pair is followed by a separate step
// for the low half) or ends the scan. A byte can cause from zero to four code
// units. The last unit of each scan is held back until the scan ends so that
// it can be marked with last_of_run, and with string_done when the byte
// carried end_of_string. A result register sits on the output, so a finished
// unit may wait for unit_ready while the next byte is already accepted.
// Malformed input never blocks: a lead byte without its continuation bytes
// becomes '#', only that lead is dropped, and the bytes behind it are decoded
// again. After a byte marked end_of_string the window is always empty.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_to_utf16_transcoder
  import utt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       byte_valid,
  output logic            byte_ready,
  input  wire byte_item_t byte_item,
  output logic            unit_valid,
  input  wire logic       unit_ready,
  output unit_item_t      unit_item
);

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_SURR = 3'b100
  } state_t;

  state_t      state;
  state_t      state_next;

  // Byte window: entries below fill are meaningful, the rest are don't-care.
  logic [7:0]  win [WIN_DEPTH];
  logic [2:0]  fill;
  logic        end_seen;

  // The most recent unit, held until we know whether it ends the run.
  logic        hold_valid;
  logic [15:0] hold_unit;
  logic        hold_sub;

  // Low surrogate waiting for its turn.
  logic [15:0] lo_unit;

  act_t        act;
  logic        out_free;
  logic        push;
  logic        push_last;
  logic        take_new;
  logic [15:0] new_unit;
  logic        new_sub;
  logic        byte_xfer;

  utt_decode u_decode (
    .win      (win),
    .fill     (fill),
    .end_seen (end_seen),
    .act      (act)
  );

  assign byte_ready = (state == ST_IDLE);
  assign byte_xfer  = byte_valid && byte_ready;
  assign out_free   = !unit_valid || unit_ready;

  // Decide what happens to the held unit and whether a new one is taken.
  // A new unit may replace the held one only when the held one can leave.
  always_comb begin
    state_next = state;
    push       = 1'b0;
    push_last  = 1'b0;
    take_new   = 1'b0;
    new_unit   = act.unit_hi;
    new_sub    = (act.kind == ACT_SUBST);
    unique case (state)
      ST_IDLE: begin
        if (byte_xfer) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (act.kind == ACT_STOP) begin
          // End of the scan: the held unit, if any, is the last of the run.
          if (!hold_valid) begin
            state_next = ST_IDLE;
          end else if (out_free) begin
            push       = 1'b1;
            push_last  = 1'b1;
            state_next = ST_IDLE;
          end
        end else if (!hold_valid || out_free) begin
          push     = hold_valid;
          take_new = 1'b1;
          if (act.kind == ACT_PAIR) state_next = ST_SURR;
        end
      end
      ST_SURR: begin
        new_unit = lo_unit;
        new_sub  = 1'b0;
        if (out_free) begin
          push       = 1'b1;
          take_new   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      fill       <= 3'd0;
      hold_valid <= 1'b0;
      unit_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (byte_xfer) begin
        fill <= fill + 3'd1;
      end else if (state == ST_SCAN && take_new) begin
        fill <= fill - act.consume;
      end
      if (take_new)       hold_valid <= 1'b1;
      else if (push_last) hold_valid <= 1'b0;
      if (push)           unit_valid <= 1'b1;
      else if (unit_ready) unit_valid <= 1'b0;
    end
  end

  // Payload registers: the window shifts left by the bytes a step consumes.
  always_ff @(posedge clk) begin
    if (byte_xfer) begin
      win[fill[1:0]] <= byte_item.in_byte;
      end_seen       <= byte_item.end_of_string;
    end else if (state == ST_SCAN && take_new) begin
      for (int i = 0; i < WIN_DEPTH; i++) begin
        if ((3'(i) + act.consume) < 3'(WIN_DEPTH)) begin
          win[i] <= win[2'(3'(i) + act.consume)];
        end
      end
    end
    if (state == ST_SCAN && take_new) lo_unit <= act.unit_lo;
    if (take_new) begin
      hold_unit <= new_unit;
      hold_sub  <= new_sub;
    end
    if (push) begin
      unit_item.utf16_unit     <= hold_unit;
      unit_item.last_of_run    <= push_last;
      unit_item.string_done    <= push_last && end_seen;
      unit_item.was_substitute <= hold_sub;
    end
  end

  // A finished scan never leaves more than three bytes behind.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (fill <= 3'd3))
    else $error("window holds more than three bytes while idle");

  // Once a string has ended, the scan stops only with an empty window.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && act.kind == ACT_STOP && end_seen) |-> (fill == 3'd0))
    else $error("bytes left pending after end of string");

  // The held unit is always sent out before a new byte is taken.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !hold_valid)
    else $error("unit still held while idle");

  // The low surrogate follows its high half without a scan in between.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && act.kind == ACT_PAIR && take_new) |=> (state == ST_SURR))
    else $error("surrogate pair split");

endmodule : utf8_to_utf16_transcoder

`default_nettype wire
